### sv/dq_pkg.sv
package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  localparam logic signed [31:0] NONE_WORD = 32'hFFFF_FFFF;
  localparam int unsigned        COUNT_W   = 11;

endpackage

### sv/double_ended_queue.sv
// Channel  Direction  Handshake             Words carried
// cmd      in         cmd_valid/cmd_stall   opcode, push_value
// rsp      out        rsp_valid/rsp_stall   popped_value, underflow, overflow,
//                                           count_after, is_empty, front_value,
//                                           back_value
// A push, a query, or a pop that leaves the deque empty is answered from S_IDLE.
// A pop that leaves words behind goes through S_WAIT first, since the new end
// word comes back through the registered read port of the single-port RAM.
// The front and back words are held in registers, so no other read is needed.
// A command is taken only while the result register is free or being taken.
// Reset empties the deque at once; the RAM contents are not cleared.
module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] push_value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] popped_value,
  output logic               underflow,
  output logic               overflow,
  output logic [dq_pkg::COUNT_W-1:0] count_after,
  output logic               is_empty,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;
  logic signed [31:0] front_word, front_next;
  logic signed [31:0] back_word, back_next;
  logic              fill_front, fill_front_next;
  logic signed [31:0] popped_next;
  logic              under_next;
  logic              over_next;
  logic              need_read;
  logic              accept;
  logic              full;
  logic              empty;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [31:0]       ram_rdata;
  logic [CW+COUNT_W-1:0] count_ext;

  assign cmd_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  dq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (push_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_next      = front_word;
    back_next       = back_word;
    fill_front_next = fill_front;
    popped_next     = NONE_WORD;
    under_next      = 1'b0;
    over_next       = 1'b0;
    need_read       = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = head;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(opcode))
            OP_PUSH_FRONT: begin
              if (full) begin
                over_next = 1'b1;
              end else begin
                head_next  = ptr_dec(head);
                ram_addr   = ptr_dec(head);
                ram_we     = 1'b1;
                count_next = count + CW'(1);
                front_next = push_value;
                if (empty) begin
                  back_next = push_value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                over_next = 1'b1;
              end else begin
                tail_next  = ptr_inc(tail);
                ram_addr   = tail;
                ram_we     = 1'b1;
                count_next = count + CW'(1);
                back_next  = push_value;
                if (empty) begin
                  front_next = push_value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                under_next = 1'b1;
              end else begin
                popped_next     = front_word;
                head_next       = ptr_inc(head);
                ram_addr        = ptr_inc(head);
                count_next      = count - CW'(1);
                need_read       = (count != CW'(1));
                fill_front_next = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                under_next = 1'b1;
              end else begin
                popped_next     = back_word;
                tail_next       = ptr_dec(tail);
                ram_addr        = ptr_dec(ptr_dec(tail));
                count_next      = count - CW'(1);
                need_read       = (count != CW'(1));
                fill_front_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
          state_next = need_read ? S_WAIT : S_IDLE;
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
        if (fill_front) begin
          front_next = ram_rdata;
        end else begin
          back_next = ram_rdata;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if ((accept && !need_read) || (state == S_WAIT)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_word <= front_next;
    back_word  <= back_next;
    fill_front <= fill_front_next;
    if (accept) begin
      popped_value <= popped_next;
      underflow    <= under_next;
      overflow     <= over_next;
      count_after  <= count_ext[COUNT_W-1:0];
      is_empty     <= (count_next == '0);
    end
  end

  assign front_value = is_empty ? NONE_WORD : front_word;
  assign back_value  = is_empty ? NONE_WORD : back_word;

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("occupancy above depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |=> (state == S_IDLE) && rsp_valid)
    else $error("read wait did not complete into a result");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> (head == tail))
    else $error("pointers disagree with occupancy");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !rsp_valid)
    else $error("result pending while a read is outstanding");

endmodule

### sv/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### tb/double_ended_queue_checker.sv
`timescale 1ns / 100ps

module double_ended_queue_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic [2:0]                   opcode,
  input  logic signed [31:0]           push_value,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  logic signed [31:0]           popped_value,
  input  logic                         underflow,
  input  logic                         overflow,
  input  logic [dq_pkg::COUNT_W-1:0]   count_after,
  input  logic                         is_empty,
  input  logic signed [31:0]           front_value,
  input  logic signed [31:0]           back_value,
  output int                           mismatches,
  output int                           outstanding
);
  import dq_pkg::*;

  typedef struct packed {
    logic signed [31:0]   popped;
    logic                 underflow;
    logic                 overflow;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
    logic signed [31:0]   front;
    logic signed [31:0]   back;
  } dq_result_t;

  logic signed [31:0] words [DEPTH];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  int unsigned stored = 0;
  dq_result_t expected_q [$];
  int fail_total = 0;
  int pending_total = 0;

  assign mismatches  = fail_total;
  assign outstanding = pending_total;

  function automatic dq_result_t apply_command(logic [2:0] op, logic signed [31:0] word);
    dq_result_t r;
    r.popped    = NONE_WORD;
    r.underflow = 1'b0;
    r.overflow  = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (stored == DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          words[head_idx] = word;
          stored++;
        end
      end
      OP_PUSH_BACK: begin
        if (stored == DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          words[tail_idx] = word;
          tail_idx = (tail_idx + 1) % DEPTH;
          stored++;
        end
      end
      OP_POP_FRONT: begin
        if (stored == 0) begin
          r.underflow = 1'b1;
        end else begin
          r.popped = words[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          stored--;
        end
      end
      OP_POP_BACK: begin
        if (stored == 0) begin
          r.underflow = 1'b1;
        end else begin
          tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
          r.popped = words[tail_idx];
          stored--;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(stored);
    r.empty = (stored == 0);
    if (stored != 0) begin
      r.front = words[head_idx];
      r.back  = words[(tail_idx + DEPTH - 1) % DEPTH];
    end else begin
      r.front = NONE_WORD;
      r.back  = NONE_WORD;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  // Inputs only move at the rising edge, so a handshake seen here is the one
  // taken at the next rising edge.
  always @(negedge clk) begin
    dq_result_t want;
    dq_result_t next_want;
    if (rst) begin
      head_idx = 0;
      tail_idx = 0;
      stored = 0;
      expected_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word arrived with no command outstanding");
          fail_total++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          compare_field("popped_value", want.popped, popped_value);
          compare_field("underflow", 32'(want.underflow), 32'(underflow));
          compare_field("overflow", 32'(want.overflow), 32'(overflow));
          compare_field("count_after", 32'(want.count), 32'(count_after));
          compare_field("is_empty", 32'(want.empty), 32'(is_empty));
          compare_field("front_value", want.front, front_value);
          compare_field("back_value", want.back, back_value);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        next_want = apply_command(opcode, push_value);
        expected_q = {expected_q, next_want};
      end
    end
    pending_total = expected_q.size();
  end

endmodule

### tb/double_ended_queue_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int CHURN_WORDS = 200;
  localparam int FILL_WORDS  = 1200;
  localparam int DRAIN_WORDS = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_SPACING = 900;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cmd_valid = 1'b0;
  logic                       cmd_stall;
  logic [2:0]                 opcode = OP_QUERY;
  logic signed [31:0]         push_value = '0;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  logic signed [31:0]         popped_value;
  logic                       underflow;
  logic                       overflow;
  logic [COUNT_W-1:0]         count_after;
  logic                       is_empty;
  logic signed [31:0]         front_value;
  logic signed [31:0]         back_value;
  int                         fails;
  int                         pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned next_hold_at = 60;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .opcode(opcode), .push_value(push_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .popped_value(popped_value), .underflow(underflow), .overflow(overflow),
    .count_after(count_after), .is_empty(is_empty),
    .front_value(front_value), .back_value(back_value)
  );

  double_ended_queue_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .opcode(opcode), .push_value(push_value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .popped_value(popped_value), .underflow(underflow), .overflow(overflow),
    .count_after(count_after), .is_empty(is_empty),
    .front_value(front_value), .back_value(back_value),
    .mismatches(fails), .outstanding(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
    end
  end

  // Now and then the receiver refuses results for a long stretch so that the
  // block backs up and stalls its command input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_word(input logic [2:0] op, input logic signed [31:0] word);
    logic taken;
    if (words_sent < 600) begin
      send_idle_pct = 25;
      recv_idle_pct = 88;
    end else if (words_sent < 1200) begin
      send_idle_pct = 88;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    opcode <= op;
    push_value <= word;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !cmd_stall;
      @(posedge clk);
    end
    words_sent++;
  endtask

  function automatic logic [2:0] pick_op(int unsigned push_pct, int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    end else if ($urandom_range(3) == 0) begin
      return 3'($urandom_range(7, OP_QUERY + 1));
    end
    return OP_QUERY;
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return NONE_WORD;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(OP_POP_FRONT, 32'sh1234_5678);
    send_word(OP_POP_BACK, 32'sh7FFF_FFFF);
    send_word(OP_QUERY, 32'sh8000_0000);
    for (int k = OP_QUERY + 1; k < 8; k++) begin
      send_word(3'(k), $urandom());
    end
    send_word(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_word(OP_PUSH_BACK, 32'sh8000_0000);
    send_word(OP_QUERY, '0);
    send_word(OP_PUSH_FRONT, NONE_WORD);
    send_word(OP_PUSH_BACK, '0);
    send_word(3'(OP_QUERY + 2), 32'sh5555_AAAA);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_FRONT, NONE_WORD);
    send_word(OP_POP_BACK, NONE_WORD);
    send_word(OP_POP_BACK, '0);
    send_word(OP_PUSH_BACK, 32'sh0000_0001);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_PUSH_FRONT, 32'shA5A5_5A5A);
    send_word(OP_POP_BACK, '0);
    send_word(OP_POP_FRONT, '0);

    repeat (CHURN_WORDS) send_word(pick_op(45, 45), pick_word());
    repeat (FILL_WORDS) send_word(pick_op(95, 4), pick_word());
    repeat (DRAIN_WORDS) send_word(pick_op(6, 90), pick_word());
    cmd_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
